[rtl/core/ciw_pkg.sv]
// ciw_pkg: shared types, constants and register map of the correlated interval walk
// used by every module under rtl/core; depends on nothing else
package ciw_pkg;

  // default values for the top-level parameters
  localparam int INTERVAL_BITS_DEF = 24;
  localparam int NOISE_BITS_DEF    = 16;

  // fixed field widths
  localparam int REG_BITS  = 24;
  localparam int CORR_BITS = 16;
  localparam int STEP_BITS = REG_BITS + 1;
  localparam int ACC_BITS  = 42;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  // register reset values
  localparam logic [REG_BITS-1:0]  MIN_IVL_RST   = 24'd50000;
  localparam logic [REG_BITS-1:0]  MAX_IVL_RST   = 24'd200000;
  localparam logic [REG_BITS-1:0]  START_IVL_RST = 24'd100000;
  localparam logic [REG_BITS-1:0]  MAX_STEP_RST  = 24'd10000;
  localparam logic [CORR_BITS-1:0] CORR_RST      = 16'd52429;
  localparam logic [REG_BITS-1:0]  TRACK_IVL_RST = 24'd50000;

  // divide by five via reciprocal: floor(y*M / 2^27) exact for y below 2^24
  localparam int                     DIV5_SHIFT = 27;
  localparam logic [REG_BITS:0]      DIV5_MULT  = 25'd26843546;
  localparam int                     DIV_PROD_BITS = 2 * REG_BITS + 1;

  // register word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_MIN_IVL   = 3'd0,
    REG_MAX_IVL   = 3'd1,
    REG_START_IVL = 3'd2,
    REG_MAX_STEP  = 3'd3,
    REG_CORR      = 3'd4,
    REG_TRACK_IVL = 3'd5
  } reg_idx_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_DIV,
    ST_INIT_LOAD,
    ST_MUL,
    ST_INNOV,
    ST_ACC,
    ST_STEP,
    ST_WALK
  } ctrl_state_t;

  // configuration register contents
  typedef struct packed {
    logic [REG_BITS-1:0]  min_ivl;
    logic [REG_BITS-1:0]  max_ivl;
    logic [REG_BITS-1:0]  start_ivl;
    logic [REG_BITS-1:0]  max_step;
    logic [CORR_BITS-1:0] corr;
    logic [REG_BITS-1:0]  track_ivl;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic init_div;
    logic init_load;
    logic mul;
    logic innov;
    logic acc;
    logic step;
    logic walk;
  } cmd_t;

endpackage

[rtl/core/ciw_regs.sv]
// ciw_regs: apb-style configuration register file with readback
// depends on ciw_pkg for the register map, widths and reset values
module ciw_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ciw_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [ciw_pkg::DATA_BITS-1:0]  pwdata,
  output logic [ciw_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output ciw_pkg::cfg_t                  cfg,
  output logic                           cfg_wr
);

  ciw_pkg::cfg_t     cfg_r;
  ciw_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = ciw_pkg::reg_idx_t'(paddr[ciw_pkg::ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // a write to a mapped register asks for a walk re-initialisation
  always_comb begin
    case (idx)
      ciw_pkg::REG_MIN_IVL,
      ciw_pkg::REG_MAX_IVL,
      ciw_pkg::REG_START_IVL,
      ciw_pkg::REG_MAX_STEP,
      ciw_pkg::REG_CORR,
      ciw_pkg::REG_TRACK_IVL: cfg_wr = wr_en;
      default:                cfg_wr = 1'b0;
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_ivl   <= ciw_pkg::MIN_IVL_RST;
      cfg_r.max_ivl   <= ciw_pkg::MAX_IVL_RST;
      cfg_r.start_ivl <= ciw_pkg::START_IVL_RST;
      cfg_r.max_step  <= ciw_pkg::MAX_STEP_RST;
      cfg_r.corr      <= ciw_pkg::CORR_RST;
      cfg_r.track_ivl <= ciw_pkg::TRACK_IVL_RST;
    end else if (wr_en) begin
      case (idx)
        ciw_pkg::REG_MIN_IVL:   cfg_r.min_ivl   <= pwdata[ciw_pkg::REG_BITS-1:0];
        ciw_pkg::REG_MAX_IVL:   cfg_r.max_ivl   <= pwdata[ciw_pkg::REG_BITS-1:0];
        ciw_pkg::REG_START_IVL: cfg_r.start_ivl <= pwdata[ciw_pkg::REG_BITS-1:0];
        ciw_pkg::REG_MAX_STEP:  cfg_r.max_step  <= pwdata[ciw_pkg::REG_BITS-1:0];
        ciw_pkg::REG_CORR:      cfg_r.corr      <= pwdata[ciw_pkg::CORR_BITS-1:0];
        ciw_pkg::REG_TRACK_IVL: cfg_r.track_ivl <= pwdata[ciw_pkg::REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (idx)
      ciw_pkg::REG_MIN_IVL:   prdata = ciw_pkg::DATA_BITS'(cfg_r.min_ivl);
      ciw_pkg::REG_MAX_IVL:   prdata = ciw_pkg::DATA_BITS'(cfg_r.max_ivl);
      ciw_pkg::REG_START_IVL: prdata = ciw_pkg::DATA_BITS'(cfg_r.start_ivl);
      ciw_pkg::REG_MAX_STEP:  prdata = ciw_pkg::DATA_BITS'(cfg_r.max_step);
      ciw_pkg::REG_CORR:      prdata = ciw_pkg::DATA_BITS'(cfg_r.corr);
      ciw_pkg::REG_TRACK_IVL: prdata = ciw_pkg::DATA_BITS'(cfg_r.track_ivl);
      default:                prdata = '0;
    endcase
  end

endmodule

[rtl/core/ciw_ctrl.sv]
// ciw_ctrl: sequencing state machine, handshakes and re-initialisation request
// depends on ciw_pkg for the state and command types
module ciw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_track_mode,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          cfg_wr,
  output ciw_pkg::cmd_t cmd
);

  ciw_pkg::ctrl_state_t state_r, state_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic                 can_take;
  logic                 accept;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign can_take  = (state_r == ciw_pkg::ST_IDLE) && !pend_r && out_free;
  assign accept    = can_take && in_valid;
  assign in_stall  = !can_take;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ciw_pkg::ST_IDLE: begin
        if (pend_r) begin
          state_nxt = ciw_pkg::ST_INIT_DIV;
        end else if (accept && !in_track_mode) begin
          state_nxt = ciw_pkg::ST_MUL;
        end
      end
      ciw_pkg::ST_INIT_DIV:  state_nxt = ciw_pkg::ST_INIT_LOAD;
      ciw_pkg::ST_INIT_LOAD: state_nxt = ciw_pkg::ST_IDLE;
      ciw_pkg::ST_MUL:       state_nxt = ciw_pkg::ST_INNOV;
      ciw_pkg::ST_INNOV:     state_nxt = ciw_pkg::ST_ACC;
      ciw_pkg::ST_ACC:       state_nxt = ciw_pkg::ST_STEP;
      ciw_pkg::ST_STEP:      state_nxt = ciw_pkg::ST_WALK;
      ciw_pkg::ST_WALK:      state_nxt = ciw_pkg::ST_IDLE;
      default:               state_nxt = ciw_pkg::ST_IDLE;
    endcase
  end

  // pending re-initialisation and output valid
  always_comb begin
    pend_nxt      = cfg_wr ? 1'b1 : ((state_r == ciw_pkg::ST_IDLE) ? 1'b0 : pend_r);
    out_valid_nxt = accept ? 1'b1 : (out_valid_r && out_stall);
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    case (state_r)
      ciw_pkg::ST_INIT_DIV:  cmd.init_div  = 1'b1;
      ciw_pkg::ST_INIT_LOAD: cmd.init_load = 1'b1;
      ciw_pkg::ST_MUL:       cmd.mul       = 1'b1;
      ciw_pkg::ST_INNOV:     cmd.innov     = 1'b1;
      ciw_pkg::ST_ACC:       cmd.acc       = 1'b1;
      ciw_pkg::ST_STEP:      cmd.step      = 1'b1;
      ciw_pkg::ST_WALK:      cmd.walk      = 1'b1;
      default: ;
    endcase
  end

  // control registers; reset requests an initial load of the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ciw_pkg::ST_IDLE;
      pend_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/ciw_dp.sv]
// ciw_dp: walk state, step arithmetic, reflection and output register
// depends on ciw_pkg for widths, constants and the command type
module ciw_dp #(
  parameter int INTERVAL_BITS = ciw_pkg::INTERVAL_BITS_DEF,
  parameter int NOISE_BITS    = ciw_pkg::NOISE_BITS_DEF
) (
  input  logic                                 clk,
  input  ciw_pkg::cfg_t                        cfg,
  input  ciw_pkg::cmd_t                        cmd,
  input  logic                                 in_track_mode,
  input  logic signed [NOISE_BITS-1:0]         in_noise_sample,
  output logic        [ciw_pkg::REG_BITS-1:0]  out_interval_us
);

  localparam int SB   = ciw_pkg::STEP_BITS;
  localparam int AB   = ciw_pkg::ACC_BITS;
  localparam int RB   = ciw_pkg::REG_BITS;
  localparam int WIDE = (INTERVAL_BITS > RB) ? INTERVAL_BITS : RB;
  localparam int CW   = WIDE + 3;
  localparam int NP   = NOISE_BITS + SB;
  localparam int DPB  = ciw_pkg::DIV_PROD_BITS;

  // payload registers
  logic        [INTERVAL_BITS-1:0] walk_interval_r, walk_interval_nxt;
  logic signed [SB-1:0]            walk_step_r, walk_step_nxt;
  logic signed [NOISE_BITS-1:0]    noise_r;
  logic        [RB-1:0]            out_interval_us_r, out_interval_us_nxt;
  logic        [DPB-1:0]           div_prod_r, div_prod_nxt;
  logic signed [NP-1:0]            noise_prod_r, noise_prod_nxt;
  logic signed [AB-1:0]            corr_prod_r, corr_prod_nxt;
  logic signed [SB-1:0]            inn_r, inn_nxt;
  logic signed [AB-1:0]            acc_r, acc_nxt;
  logic signed [SB-1:0]            step_new_r, step_new_nxt;

  // helpers
  logic        [WIDE-1:0]          ivl_ext;
  logic signed [SB-1:0]            lim_s;
  logic signed [RB:0]              range_s;
  logic        [RB:0]              range_rnd;
  logic        [DPB-1:0]           tenth;
  logic signed [SB-1:0]            init_step;
  logic signed [ciw_pkg::CORR_BITS:0]   corr_s;
  logic        [ciw_pkg::CORR_BITS:0]   wcorr;
  logic signed [ciw_pkg::CORR_BITS+1:0] wcorr_s;
  logic        [NP-1:0]            nmag, nrnd;
  logic signed [SB-1:0]            inn_mag;
  logic        [AB-1:0]            amag, arnd;
  logic        [SB-1:0]            lim_u;
  logic        [SB-1:0]            sat_mag;
  logic signed [CW-1:0]            cand, refl, clamp_lo, clamp_hi, lo_s, hi_s;
  logic signed [SB-1:0]            step_fin;

  assign ivl_ext         = WIDE'(walk_interval_r);
  assign lim_s           = signed'({1'b0, cfg.max_step});
  assign lim_u           = {1'b0, cfg.max_step};
  assign out_interval_us = out_interval_us_r;

  // result of the transaction: track value or the walk interval before this step
  assign out_interval_us_nxt = in_track_mode ? cfg.track_ivl : ivl_ext[RB-1:0];

  // initial step: round((max - min) / 10) as floor(floor((range + 5) / 2) / 5)
  always_comb begin
    range_s      = signed'({1'b0, cfg.max_ivl}) - signed'({1'b0, cfg.min_ivl});
    range_rnd    = (range_s > 0) ? unsigned'(range_s) + (RB + 1)'(5) : '0;
    div_prod_nxt = DPB'(range_rnd[RB:1]) * DPB'(ciw_pkg::DIV5_MULT);
    tenth        = div_prod_r >> ciw_pkg::DIV5_SHIFT;
    init_step    = (DPB'(cfg.max_step) < tenth) ? lim_s : signed'(SB'(tenth));
  end

  // product stage: noise times step limit, correlation times old step
  always_comb begin
    corr_s         = signed'({1'b0, cfg.corr});
    noise_prod_nxt = NP'(noise_r) * NP'(lim_s);
    corr_prod_nxt  = AB'(corr_s) * AB'(walk_step_r);
  end

  // innovation: round the noise product to whole microseconds
  always_comb begin
    nmag    = noise_prod_r[NP-1] ? unsigned'(-noise_prod_r) : unsigned'(noise_prod_r);
    nrnd    = (nmag + (NP'(1) << (NOISE_BITS - 2))) >> (NOISE_BITS - 1);
    inn_mag = signed'(SB'(nrnd));
    inn_nxt = noise_prod_r[NP-1] ? -inn_mag : inn_mag;
  end

  // blend: corr * step + (1 - corr) * innovation, in q16
  always_comb begin
    wcorr   = (ciw_pkg::CORR_BITS + 1)'(1 << ciw_pkg::CORR_BITS) - {1'b0, cfg.corr};
    wcorr_s = signed'({1'b0, wcorr});
    acc_nxt = corr_prod_r + AB'(wcorr_s) * AB'(inn_r);
  end

  // new step: round out of q16 and saturate to the step limit
  always_comb begin
    amag         = acc_r[AB-1] ? unsigned'(-acc_r) : unsigned'(acc_r);
    arnd         = (amag + (AB'(1) << 15)) >> 16;
    sat_mag      = (arnd > AB'(lim_u)) ? lim_u : SB'(arnd);
    step_new_nxt = acc_r[AB-1] ? -signed'(sat_mag) : signed'(sat_mag);
  end

  // advance, reflect at a crossed bound, then clamp (upper bound wins)
  always_comb begin
    lo_s     = CW'(signed'({1'b0, cfg.min_ivl}));
    hi_s     = CW'(signed'({1'b0, cfg.max_ivl}));
    cand     = CW'(signed'({1'b0, walk_interval_r})) + CW'(step_new_r);
    refl     = cand;
    step_fin = step_new_r;
    if (cand > hi_s) begin
      refl = (hi_s <<< 1) - cand;
      if (step_new_r > 0) begin
        step_fin = -step_new_r;
      end
    end else if (cand < lo_s) begin
      refl = (lo_s <<< 1) - cand;
      if (step_new_r < 0) begin
        step_fin = -step_new_r;
      end
    end
    clamp_lo          = (refl < lo_s) ? lo_s : refl;
    clamp_hi          = (clamp_lo > hi_s) ? hi_s : clamp_lo;
    walk_interval_nxt = clamp_hi[INTERVAL_BITS-1:0];
    walk_step_nxt     = step_fin;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      noise_r           <= in_noise_sample;
      out_interval_us_r <= out_interval_us_nxt;
    end
    if (cmd.init_div) begin
      div_prod_r <= div_prod_nxt;
    end
    if (cmd.init_load) begin
      walk_interval_r <= INTERVAL_BITS'(cfg.start_ivl);
      walk_step_r     <= init_step;
    end
    if (cmd.mul) begin
      noise_prod_r <= noise_prod_nxt;
      corr_prod_r  <= corr_prod_nxt;
    end
    if (cmd.innov) begin
      inn_r <= inn_nxt;
    end
    if (cmd.acc) begin
      acc_r <= acc_nxt;
    end
    if (cmd.step) begin
      step_new_r <= step_new_nxt;
    end
    if (cmd.walk) begin
      walk_interval_r <= walk_interval_nxt;
      walk_step_r     <= walk_step_nxt;
    end
  end

endmodule

[rtl/core/correlated_interval_walk.sv]
// correlated_interval_walk: result is registered the cycle after a request is taken.
// track requests: one per cycle while the result is not stalled; a walk request is
// taken only once the sequencer has stepped the two multiply stages, two rounding
// stages and reflection. reset (rst_n low, synchronous) loads register defaults;
// after reset or a write to a mapped register the walk re-initialises, input stalled.
// depends on ciw_pkg, ciw_regs, ciw_ctrl and ciw_dp
module correlated_interval_walk #(
  parameter int INTERVAL_BITS = ciw_pkg::INTERVAL_BITS_DEF,
  parameter int NOISE_BITS    = ciw_pkg::NOISE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_track_mode,
  input  logic signed [NOISE_BITS-1:0]         in_noise_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [ciw_pkg::REG_BITS-1:0]  out_interval_us,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [ciw_pkg::ADDR_BITS-1:0] paddr,
  input  logic        [ciw_pkg::DATA_BITS-1:0] pwdata,
  output logic        [ciw_pkg::DATA_BITS-1:0] prdata,
  output logic                                 pready
);

  ciw_pkg::cfg_t cfg;
  ciw_pkg::cmd_t cmd;
  logic          cfg_wr;

  // configuration registers
  ciw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // sequencer
  ciw_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_track_mode (in_track_mode),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cfg_wr        (cfg_wr),
    .cmd           (cmd)
  );

  // arithmetic and walk state
  ciw_dp #(
    .INTERVAL_BITS (INTERVAL_BITS),
    .NOISE_BITS    (NOISE_BITS)
  ) u_dp (
    .clk             (clk),
    .cfg             (cfg),
    .cmd             (cmd),
    .in_track_mode   (in_track_mode),
    .in_noise_sample (in_noise_sample),
    .out_interval_us (out_interval_us)
  );

endmodule

[rtl/core/ciw_checker.sv]
// ciw_checker: port-level checks of the correlated interval walk, bound to the top level
// depends on ciw_pkg for port widths and the register map
module ciw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_track_mode,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ciw_pkg::REG_BITS-1:0]  out_interval_us,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [ciw_pkg::ADDR_BITS-1:0] paddr,
  input logic                          pready
);

  // reset leaves a walk re-initialisation pending, so input is held off
  a_reset_stalls: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // a write to a mapped register re-initialises the walk before the next transaction
  a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready &&
     (paddr[ciw_pkg::ADDR_BITS-1:2] <= ciw_pkg::REG_TRACK_IVL)) |=> in_stall)
    else $error("input not stalled after register write");

  // a walk transaction occupies the sequencer and registers its result
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_track_mode) |=> (in_stall && out_valid))
    else $error("walk transaction did not hold off input or give a result");

  // an accepted track transaction gives a result on the next cycle
  a_track_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_track_mode) |=> out_valid)
    else $error("track transaction gave no result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_interval_us)))
    else $error("stalled result changed");

endmodule

bind correlated_interval_walk ciw_checker u_ciw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_track_mode   (in_track_mode),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_interval_us (out_interval_us),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pready          (pready)
);

[tb/sv/ciw_walk_checker.sv]
// ciw_walk_checker: follows the register port, request and result channels of the
// interval walk, predicts every interval and compares it with the block's output
// depends on ciw_pkg
module ciw_walk_checker (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  logic                                        in_stall,
  input  logic                                        in_track_mode,
  input  logic signed [ciw_pkg::NOISE_BITS_DEF-1:0]   in_noise_sample,
  input  logic                                        out_valid,
  input  logic                                        out_stall,
  input  logic        [ciw_pkg::REG_BITS-1:0]         out_interval_us,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic                                        pready,
  input  logic        [ciw_pkg::ADDR_BITS-1:0]        paddr,
  input  logic        [ciw_pkg::DATA_BITS-1:0]        pwdata,
  output int                                          fail_count,
  output int                                          outstanding
);

  localparam int IVL_BITS   = ciw_pkg::INTERVAL_BITS_DEF;
  localparam int NOISE_BITS = ciw_pkg::NOISE_BITS_DEF;
  localparam int REG_BITS   = ciw_pkg::REG_BITS;
  localparam int STEP_BITS  = ciw_pkg::STEP_BITS;
  localparam int CORR_BITS  = ciw_pkg::CORR_BITS;
  localparam int DATA_BITS  = ciw_pkg::DATA_BITS;
  localparam int ADDR_BITS  = ciw_pkg::ADDR_BITS;

  // predictor copy of the registers and the walk
  ciw_pkg::cfg_t               cfg;
  logic [IVL_BITS-1:0]         walk_ivl;
  logic signed [STEP_BITS-1:0] walk_step;

  // intervals still owed by the block, oldest first
  logic [REG_BITS-1:0] interval_q[$];
  logic [REG_BITS-1:0] expected;
  int                  n_fail = 0;

  // shift right with rounding to nearest, ties away from zero
  function automatic longint round_away(longint x, int s);
    longint mag;
    longint r;
    mag = (x < 0) ? -x : x;
    r = (mag + (longint'(1) <<< (s - 1))) >>> s;
    return (x < 0) ? -r : r;
  endfunction

  // reload the walk from the start interval, step from a tenth of the range
  function automatic void restart_walk();
    longint range;
    longint tenth;
    range = longint'(cfg.max_ivl) - longint'(cfg.min_ivl);
    tenth = (range > 0) ? (range + 5) / 10 : 0;
    walk_ivl = IVL_BITS'(cfg.start_ivl);
    walk_step = (longint'(cfg.max_step) < tenth) ? STEP_BITS'(cfg.max_step)
                                                 : STEP_BITS'(tenth);
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [DATA_BITS-1:0] data);
    case (idx)
      ciw_pkg::REG_MIN_IVL:   cfg.min_ivl   = data[REG_BITS-1:0];
      ciw_pkg::REG_MAX_IVL:   cfg.max_ivl   = data[REG_BITS-1:0];
      ciw_pkg::REG_START_IVL: cfg.start_ivl = data[REG_BITS-1:0];
      ciw_pkg::REG_MAX_STEP:  cfg.max_step  = data[REG_BITS-1:0];
      ciw_pkg::REG_CORR:      cfg.corr      = data[CORR_BITS-1:0];
      ciw_pkg::REG_TRACK_IVL: cfg.track_ivl = data[REG_BITS-1:0];
      default:                return;
    endcase
    restart_walk();
  endfunction

  // interval returned for one request; advances the walk unless tracking
  function automatic logic [REG_BITS-1:0] next_interval(
    logic track, logic signed [NOISE_BITS-1:0] noise);
    longint lim;
    longint lo;
    longint hi;
    longint corr;
    longint innov;
    longint acc;
    longint step;
    longint cand;
    logic [REG_BITS-1:0] shown;
    if (track) return cfg.track_ivl;
    lim = longint'(cfg.max_step);
    lo = longint'(cfg.min_ivl);
    hi = longint'(cfg.max_ivl);
    corr = longint'(cfg.corr);
    shown = walk_ivl[REG_BITS-1:0];

    // correlated step, saturated to the step limit
    innov = round_away(longint'(noise) * lim, NOISE_BITS - 1);
    acc = corr * longint'(walk_step) + ((longint'(1) <<< CORR_BITS) - corr) * innov;
    step = round_away(acc, CORR_BITS);
    if (step > lim) step = lim;
    if (step < -lim) step = -lim;

    // reflect at a crossed bound with the step turned inward, then clamp
    cand = longint'(walk_ivl) + step;
    if (cand > hi) begin
      cand = 2 * hi - cand;
      if (step > 0) step = -step;
    end else if (cand < lo) begin
      cand = 2 * lo - cand;
      if (step < 0) step = -step;
    end
    if (cand < lo) cand = lo;
    if (cand > hi) cand = hi;

    walk_step = STEP_BITS'(step);
    walk_ivl = IVL_BITS'(cand);
    return shown;
  endfunction

  // register writes, then results, then requests of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg = '{min_ivl: ciw_pkg::MIN_IVL_RST, max_ivl: ciw_pkg::MAX_IVL_RST,
              start_ivl: ciw_pkg::START_IVL_RST, max_step: ciw_pkg::MAX_STEP_RST,
              corr: ciw_pkg::CORR_RST, track_ivl: ciw_pkg::TRACK_IVL_RST};
      restart_walk();
      interval_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[ADDR_BITS-1:2], pwdata);
      if (out_valid && !out_stall) begin
        if (interval_q.size() == 0) begin
          n_fail++;
          $error("interval_us: no transaction expected, actual %0d", out_interval_us);
        end else begin
          expected = interval_q.pop_front();
          if (out_interval_us !== expected) begin
            n_fail++;
            $error("interval_us mismatch: expected %0d, actual %0d", expected,
                   out_interval_us);
          end
        end
      end
      if (in_valid && !in_stall)
        interval_q.push_back(next_interval(in_track_mode, in_noise_sample));
    end
    fail_count <= n_fail;
    outstanding <= interval_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
// tb_top: drives requests, result stalls and register writes into the interval walk
// and gives the verdict; depends on ciw_pkg, ciw_walk_checker and the block itself
module tb_top;

  localparam int NOISE_W         = ciw_pkg::NOISE_BITS_DEF;
  localparam int REG_BITS        = ciw_pkg::REG_BITS;
  localparam int CORR_BITS       = ciw_pkg::CORR_BITS;
  localparam int ADDR_BITS       = ciw_pkg::ADDR_BITS;
  localparam int DATA_BITS       = ciw_pkg::DATA_BITS;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int SETTLE_CYCLES   = 20;
  localparam logic [2:0] SPARE_REG_IDX = 3'd6;
  localparam logic [REG_BITS-1:0]  FULL24 = '1;
  localparam logic [CORR_BITS-1:0] FULL16 = '1;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = {1'b1, {(NOISE_W-1){1'b0}}};
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = ~NOISE_MIN;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_track_mode;
  logic signed [NOISE_W-1:0]     in_noise_sample;
  logic                          out_valid;
  logic                          out_stall;
  logic [REG_BITS-1:0]           out_interval_us;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ADDR_BITS-1:0]          paddr;
  logic [DATA_BITS-1:0]          pwdata;
  logic [DATA_BITS-1:0]          prdata;
  logic                          pready;

  int          fail_count;
  int          outstanding;
  int          in_gap_pct = 0;
  int          out_stall_pct = 0;
  int unsigned n_walk = 0;
  int unsigned n_track = 0;
  int unsigned n_writes = 0;

  correlated_interval_walk i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_track_mode   (in_track_mode),
    .in_noise_sample (in_noise_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_interval_us (out_interval_us),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  ciw_walk_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_track_mode   (in_track_mode),
    .in_noise_sample (in_noise_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_interval_us (out_interval_us),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #3000000;
    $error("run did not complete in the allowed time");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && $urandom_range(1, 100) <= out_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one request transaction; valid stays high for a following request
  task automatic send_request(logic track, logic signed [NOISE_W-1:0] noise);
    if (in_gap_pct > 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_track_mode <= track;
    in_noise_sample <= noise;
    do @(posedge clk); while (in_stall);
    if (track) n_track++;
    else n_walk++;
  endtask

  // hold off requests until every owed interval is back and the walk is idle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || in_stall);
  endtask

  // setup and access cycle of one register write, then the bus is left idle
  task automatic program_register(logic [2:0] idx, logic [DATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n_writes++;
    @(posedge clk);
  endtask

  // full register set, junk in the unused upper bits
  task automatic load_walk_config(logic [REG_BITS-1:0] lo, logic [REG_BITS-1:0] hi,
                                  logic [REG_BITS-1:0] start, logic [REG_BITS-1:0] step,
                                  logic [CORR_BITS-1:0] corr,
                                  logic [REG_BITS-1:0] track);
    wait_for_results();
    program_register(ciw_pkg::REG_MIN_IVL,   {8'($urandom), lo});
    program_register(ciw_pkg::REG_MAX_IVL,   {8'($urandom), hi});
    program_register(ciw_pkg::REG_START_IVL, {8'($urandom), start});
    program_register(ciw_pkg::REG_MAX_STEP,  {8'($urandom), step});
    program_register(ciw_pkg::REG_CORR,      {16'($urandom), corr});
    program_register(ciw_pkg::REG_TRACK_IVL, {8'($urandom), track});
  endtask

  function automatic logic signed [NOISE_W-1:0] pick_noise();
    if ($urandom_range(0, 9) != 0) return NOISE_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return NOISE_MIN;
      1:       return NOISE_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // stimulus
  initial begin
    logic [REG_BITS-1:0] lo;
    logic [REG_BITS-1:0] hi;
    logic [REG_BITS-1:0] start;
    logic [REG_BITS-1:0] step;
    logic [CORR_BITS-1:0] corr;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_track_mode <= 1'b0;
    in_noise_sample <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: noise extremes, sign boundary, track mode
    in_gap_pct = 20;
    out_stall_pct = 20;
    send_request(1'b1, '0);
    send_request(1'b0, NOISE_MAX);
    send_request(1'b0, NOISE_MIN);
    send_request(1'b0, '0);
    send_request(1'b0, '1);
    send_request(1'b0, 16'sd1);
    send_request(1'b1, NOISE_MIN);

    // tight band: reflection at the upper then the lower bound
    load_walk_config(24'd1000, 24'd1100, 24'd1090, 24'd50, '0, 24'd777);
    repeat (2) send_request(1'b0, NOISE_MAX);
    repeat (3) send_request(1'b0, NOISE_MIN);

    // empty range, so the walk starts with no step
    load_walk_config(24'd3000, 24'd3000, 24'd3000, 24'd100, 16'd32768, 24'd1);
    send_request(1'b0, NOISE_MAX);
    send_request(1'b0, NOISE_MIN);

    // reversed bounds: the upper bound wins the clamp
    load_walk_config(24'd9000, 24'd3000, 24'd6000, 24'd400, 16'd16384, 24'd2);
    send_request(1'b0, NOISE_MAX);
    send_request(1'b0, NOISE_MIN);
    send_request(1'b0, '0);

    // start value outside the bounds is taken as it is
    load_walk_config(24'd1000, 24'd2000, 24'd50000, 24'd300, 16'd40000, 24'd3);
    send_request(1'b0, '0);
    send_request(1'b0, NOISE_MAX);

    // every register zero
    load_walk_config('0, '0, '0, '0, '0, '0);
    send_request(1'b1, NOISE_MAX);
    send_request(1'b0, NOISE_MAX);

    // widest settings
    load_walk_config('0, FULL24, FULL24, FULL24, FULL16, FULL24);
    send_request(1'b0, NOISE_MAX);
    send_request(1'b0, NOISE_MIN);
    send_request(1'b1, '0);

    // unused register address leaves the walk running
    wait_for_results();
    program_register(SPARE_REG_IDX, $urandom);
    send_request(1'b0, NOISE_MIN);

    // random settings, each followed by a run of random requests
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          lo = REG_BITS'($urandom_range(1, 1 << 20));
          hi = lo + REG_BITS'($urandom_range(0, 1 << 16));
          start = REG_BITS'($urandom_range(lo, hi));
          step = REG_BITS'($urandom_range(1, 1 << 14));
          corr = CORR_BITS'($urandom);
        end
        1: begin
          lo = REG_BITS'($urandom);
          hi = REG_BITS'($urandom);
          start = REG_BITS'($urandom);
          step = REG_BITS'($urandom);
          corr = CORR_BITS'($urandom);
        end
        2: begin
          lo = $urandom_range(0, 1) ? '0 : REG_BITS'($urandom_range(0, 1 << 12));
          hi = FULL24;
          start = REG_BITS'($urandom);
          step = $urandom_range(0, 1) ? FULL24
                                      : REG_BITS'($urandom_range(1 << 20, 1 << 23));
          corr = $urandom_range(0, 1) ? FULL16 : '0;
        end
        default: begin
          lo = REG_BITS'($urandom_range(0, 1 << 23));
          hi = lo + REG_BITS'($urandom_range(1, 1000));
          start = REG_BITS'($urandom_range(lo, hi));
          step = REG_BITS'($urandom_range(500, 5000));
          corr = CORR_BITS'($urandom);
        end
      endcase
      load_walk_config(lo, hi, start, step, corr, REG_BITS'($urandom));
      if (p == 2) program_register(SPARE_REG_IDX, $urandom);

      // idling varies per setting, none at all in the last one
      if (p == RANDOM_PHASES - 1) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      end

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ((p == 0 && k == 50) || $urandom_range(0, 199) == 0) wait_for_results();
        send_request($urandom_range(0, 4) == 0, pick_noise());
      end
    end

    // let the last results drain
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d walk and %0d track requests, %0d register writes",
             n_walk, n_track, n_writes);
    $display("settings: reset, directed corner cases and %0d random sets", RANDOM_PHASES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
